// ----- design/utf8e_pkg.sv -----
`default_nettype none

package utf8e_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [15:0] BUDGET_RESET = 16'hFFFF;

  localparam logic [31:0] CP_MAX_1B = 32'h0000_007F;
  localparam logic [31:0] CP_MAX_2B = 32'h0000_07FF;
  localparam logic [31:0] CP_MAX_3B = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX_4B = 32'h0010_FFFF;

  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] CONT_HI = 8'h80;

  typedef enum logic [1:0] {
    KIND_DATA        = 2'd0,
    KIND_END_OK      = 2'd1,
    KIND_END_INVALID = 2'd2
  } kind_t;

  // One queued job for the back end: either the bytes of one character or
  // a single end-of-string item.
  typedef struct packed {
    kind_t           kind;
    logic [15:0]     total;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } cmd_t;

  // Byte 0 goes out first.
  function automatic logic [3:0][7:0] utf8_bytes(input logic [20:0] cp,
                                                 input logic [1:0]  last_idx);
    logic [3:0][7:0] b;
    b = '0;
    case (last_idx)
      2'd0: begin
        b[0] = {1'b0, cp[6:0]};
      end
      2'd1: begin
        b[0] = LEAD_2B | {3'b000, cp[10:6]};
        b[1] = CONT_HI | {2'b00, cp[5:0]};
      end
      2'd2: begin
        b[0] = LEAD_3B | {4'b0000, cp[15:12]};
        b[1] = CONT_HI | {2'b00, cp[11:6]};
        b[2] = CONT_HI | {2'b00, cp[5:0]};
      end
      default: begin
        b[0] = LEAD_4B | {5'b00000, cp[20:18]};
        b[1] = CONT_HI | {2'b00, cp[17:12]};
        b[2] = CONT_HI | {2'b00, cp[11:6]};
        b[3] = CONT_HI | {2'b00, cp[5:0]};
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- design/utf8e_front.sv -----
`default_nettype none

module utf8e_front #(
  parameter int LENGTH_BITS = utf8e_pkg::LENGTH_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [15:0]      cfg_wr_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [31:0]      in_tdata,
  input  wire logic             q_full,
  output logic                  q_push,
  output utf8e_pkg::cmd_t       q_cmd
);
  import utf8e_pkg::*;

  // Compare width covers both the count plus a character and the budget.
  localparam int CmpW = (LENGTH_BITS + 1 > 17) ? LENGTH_BITS + 1 : 17;

  logic [15:0]            budget_r;
  logic [LENGTH_BITS-1:0] bytes_used_r, bytes_used_nxt;
  logic                   stopped_r, stopped_nxt;
  logic                   invalid_r, invalid_nxt;

  logic            accept;
  logic            is_end;
  logic            is_bad;
  logic [2:0]      size;
  logic [1:0]      last_idx;
  logic [CmpW-1:0] sum_w;
  logic [CmpW-1:0] budget_w;
  logic [CmpW-1:0] max_w;
  logic [CmpW-1:0] limit_w;
  logic            over;
  logic [31:0]     used_ext;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    is_end = (in_tdata == 32'd0);
    is_bad = 1'b0;
    if (in_tdata <= CP_MAX_1B) begin
      size = 3'd1;
    end else if (in_tdata <= CP_MAX_2B) begin
      size = 3'd2;
    end else if (in_tdata <= CP_MAX_3B) begin
      size = 3'd3;
    end else if (in_tdata <= CP_MAX_4B) begin
      size = 3'd4;
    end else begin
      size   = 3'd4;
      is_bad = 1'b1;
    end
    last_idx = 2'(size - 3'd1);

    sum_w    = CmpW'(bytes_used_r) + CmpW'(size);
    budget_w = CmpW'(budget_r);
    max_w    = CmpW'({LENGTH_BITS{1'b1}});
    limit_w  = (budget_w < max_w) ? budget_w : max_w;
    over     = (sum_w > limit_w);
    used_ext = 32'(bytes_used_r);

    bytes_used_nxt = bytes_used_r;
    stopped_nxt    = stopped_r;
    invalid_nxt    = invalid_r;
    q_push         = 1'b0;
    q_cmd.kind     = KIND_DATA;
    q_cmd.total    = 16'd0;
    q_cmd.last_idx = last_idx;
    q_cmd.bytes    = utf8_bytes(in_tdata[20:0], last_idx);

    if (accept) begin
      if (is_end) begin
        q_push         = 1'b1;
        q_cmd.kind     = invalid_r ? KIND_END_INVALID : KIND_END_OK;
        q_cmd.total    = used_ext[15:0];
        q_cmd.last_idx = 2'd0;
        q_cmd.bytes    = '0;
        bytes_used_nxt = '0;
        stopped_nxt    = 1'b0;
        invalid_nxt    = 1'b0;
      end else if (!stopped_r) begin
        if (is_bad) begin
          stopped_nxt = 1'b1;
          invalid_nxt = 1'b1;
        end else if (over) begin
          stopped_nxt = 1'b1;
        end else begin
          q_push         = 1'b1;
          bytes_used_nxt = sum_w[LENGTH_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r     <= BUDGET_RESET;
      bytes_used_r <= '0;
      stopped_r    <= 1'b0;
      invalid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      bytes_used_r <= bytes_used_nxt;
      stopped_r    <= stopped_nxt;
      invalid_r    <= invalid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/utf8e_queue.sv -----
`default_nettype none

module utf8e_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire utf8e_pkg::cmd_t push_cmd,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output utf8e_pkg::cmd_t      head_cmd
);
  import utf8e_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = (count_r == CntW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- design/utf8e_back.sv -----
`default_nettype none

module utf8e_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire utf8e_pkg::cmd_t head_cmd,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [23:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);
  import utf8e_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r;
  logic [15:0] total_r;
  kind_t       kind_r;
  logic        last_r;

  logic load;
  logic at_last;

  assign out_tvalid = valid_r;
  assign out_tdata  = {total_r, byte_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  // The output register reloads when a queue entry waits and it is empty or
  // being drained, so a byte leaves every cycle while the receiver keeps up.
  always_comb begin
    load      = head_valid && (!valid_r || out_tready);
    at_last   = (idx_r == head_cmd.last_idx);
    pop       = load && at_last;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= head_cmd.bytes[idx_r];
      total_r <= head_cmd.total;
      kind_r  <= head_cmd.kind;
      last_r  <= at_last;
    end
  end

endmodule

`default_nettype wire

// ----- design/utf8_encoder_with_budget_core.sv -----
// UTF-8 encoder with a per-string byte budget.
//
// The input stream carries one 32-bit code point per transaction; a zero
// code point ends the current string. Each character is turned into one to
// four byte transactions on the output stream, tlast marking the final byte
// of a character. A string end gives one transaction with the byte count in
// tdata[23:8] and the status in tuser. Characters that would overrun the
// budget, or that lie above U+10FFFF, cut the string: they and everything
// up to the terminator produce nothing. The budget register is written via
// cfg_wr_en/cfg_wr_data; the user must do so only while idle (not enforced).
//
// An accepted input passes through the queue and then the output register
// before its first byte appears on the output.
// The output side moves one byte per cycle while the receiver keeps up, and
// a character gives one to four bytes of the serialiser; input is taken every
// cycle while the two-entry queue in front of the serialiser has room.
// A stall on the output holds the output register and fills the queue, after
// which in_tready drops. Reset clears the count, the flags and the queue, and
// sets the budget to 65535.
`default_nettype none

module utf8_encoder_with_budget_core #(
  parameter int LENGTH_BITS = utf8e_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] code_point
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [23:8] total_length
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast
);
  import utf8e_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_cmd;
  cmd_t q_head;

  utf8e_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  utf8e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .head_valid(q_head_valid),
    .head_cmd  (q_head)
  );

  utf8e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_head_valid),
    .head_cmd  (q_head),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

`default_nettype wire

// ----- design/utf8e_checker.sv -----
`default_nettype none

module utf8e_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);
  import utf8e_pkg::*;

  // A stalled output transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  // Data bytes never carry a length.
  a_data_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_DATA) |-> (out_tdata[23:8] == 16'd0))
    else $error("data byte carries a length");

  // End transactions are single items with a zero byte.
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_DATA) |-> out_tlast && (out_tdata[7:0] == 8'd0))
    else $error("malformed end transaction");

endmodule

bind utf8_encoder_with_budget_core utf8e_checker u_utf8e_checker (.*);

`default_nettype wire
